FILE: sv/psev_pkg.sv
// Shared word widths, token opcodes and result status codes for the postfix evaluator.
package psev_pkg;

  localparam int WORD_W   = 32;
  localparam int OPND_W   = 31;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY_END = 3'd4;

endpackage

FILE: sv/psev_tok_if.sv
// Token channel: valid/ready handshake carrying one postfix token per beat.
interface psev_tok_if;
  import psev_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [OPND_W-1:0] operand_value;
  logic              last_token;

  modport source (output valid, output opcode, output operand_value, output last_token,
                  input ready);
  modport sink   (input valid, input opcode, input operand_value, input last_token,
                  output ready);
endinterface

FILE: sv/psev_res_if.sv
// Result channel: valid/ready handshake carrying one step result per beat.
interface psev_res_if #(
  parameter int DEPTH_W = 5
);
  import psev_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [WORD_W-1:0]   top_value;
  logic [STATUS_W-1:0]        status;
  logic                       is_final;
  logic [DEPTH_W-1:0]         stack_depth;

  modport source (output valid, output top_value, output status, output is_final,
                  output stack_depth, input ready);
  modport sink   (input valid, input top_value, input status, input is_final,
                  input stack_depth, output ready);
endinterface

FILE: sv/psev_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/psev_div.sv
// Signed 32-bit divider, truncating toward zero, one restoring step per cycle.
module psev_div import psev_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic              done,
  output logic [WORD_W-1:0] quo
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] qsh;
  logic [WORD_W-1:0] dmag;
  logic              neg;

  logic [WORD_W:0] rem_sh;
  logic [WORD_W:0] diff;

  assign rem_sh = {rem, qsh[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dmag};
  // magnitude of the most negative numerator is 2^31, negated back it wraps as required
  assign quo    = neg ? (~qsh + WORD_W'(1)) : qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        qsh  <= num[WORD_W-1] ? (~num + WORD_W'(1)) : num;
        dmag <= den[WORD_W-1] ? (~den + WORD_W'(1)) : den;
        neg  <= num[WORD_W-1] ^ den[WORD_W-1];
      end else if (busy) begin
        if (!diff[WORD_W]) begin
          rem <= diff[WORD_W-1:0];
          qsh <= {qsh[WORD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WORD_W-1:0];
          qsh <= {qsh[WORD_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/postfix_stack_evaluator.sv
// Postfix evaluator top level: stack in RAM, top entry cached in a register.
//
//   channel  dir  handshake     payload
//   tok      in   valid/ready   opcode, operand_value, last_token
//   res      out  valid/ready   top_value, status, is_final, stack_depth
//
// Push, error and ignored tokens: accept, then result load.
// Add, subtract, multiply: accept + RAM read of second entry, execute, write back,
// result load. Divide: as these, with a wait on the 32-step divider after execute.
// One token is in flight at a time; tok.ready is low until its result is in the
// output register. A stalled res holds the finished result and the next token
// waits in the load state. Synchronous reset empties the stack at once.
module postfix_stack_evaluator import psev_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  psev_tok_if.sink   tok,
  psev_res_if.source res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_WB, S_DONE} state_t;

  state_t              state;
  logic [PW-1:0]       sp;
  logic [WORD_W-1:0]   top_q;
  logic [OP_W-1:0]     op_q;
  logic                last_q;
  logic [WORD_W-1:0]   r_val;
  logic [WORD_W-1:0]   pend_top;
  logic [STATUS_W-1:0] pend_status;
  logic [PW-1:0]       pend_depth;

  logic                tok_fire;
  logic [PW-1:0]       sp_m2;
  logic [PW-1:0]       sp_m1;
  logic [WORD_W-1:0]   cur_top;
  logic                full;
  logic                push_we;
  logic                go_exec;
  logic [WORD_W-1:0]   imm_top;
  logic [STATUS_W-1:0] imm_status;
  logic [PW-1:0]       imm_depth;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   mul_lo;
  logic                div_start;
  logic                div_done;
  logic [WORD_W-1:0]   div_quo;

  assign tok.ready = (state == S_IDLE);
  assign tok_fire  = tok.valid && tok.ready;
  assign sp_m2     = sp - PW'(2);
  assign sp_m1     = sp - PW'(1);
  assign full      = (sp == PW'(STACK_DEPTH));
  assign cur_top   = (sp != '0) ? top_q : '0;
  assign mul_lo    = ram_rdata * top_q;
  assign div_start = (state == S_EXEC) && (op_q == OP_DIV);

  always_comb begin
    imm_status = ST_OK;
    imm_top    = cur_top;
    imm_depth  = sp;
    push_we    = 1'b0;
    go_exec    = 1'b0;
    case (tok.opcode)
      OP_PUSH: begin
        if (full) begin
          imm_status = ST_OVERFLOW;
        end else begin
          push_we   = 1'b1;
          imm_top   = {1'b0, tok.operand_value};
          imm_depth = sp + PW'(1);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (sp < PW'(2)) begin
          imm_status = ST_UNDERFLOW;
        end else if (tok.opcode == OP_DIV && top_q == '0) begin
          imm_status = ST_DIVZERO;
        end else begin
          go_exec = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (tok.last_token && imm_status == ST_OK && imm_depth == '0) begin
      imm_status = ST_EMPTY_END;
    end
  end

  // one write port: pushes from the accept cycle, operator results from write back
  assign ram_we    = (tok_fire && push_we) || (state == S_WB);
  assign ram_waddr = (state == S_WB) ? sp_m2[AW-1:0] : sp[AW-1:0];
  assign ram_wdata = (state == S_WB) ? r_val : {1'b0, tok.operand_value};

  psev_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (tok_fire && go_exec),
    .raddr (sp_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  psev_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ram_rdata),
    .den   (top_q),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      res.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tok_fire) begin
            op_q        <= tok.opcode;
            last_q      <= tok.last_token;
            pend_top    <= imm_top;
            pend_status <= imm_status;
            pend_depth  <= imm_depth;
            if (push_we) begin
              top_q <= {1'b0, tok.operand_value};
            end
            if (!go_exec && tok.last_token) begin
              sp <= '0;
            end else if (push_we) begin
              sp <= sp + PW'(1);
            end
            if (go_exec) begin
              state <= S_EXEC;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_EXEC: begin
          // ram_rdata is the second entry, top_q the top
          case (op_q)
            OP_ADD:  r_val <= ram_rdata + top_q;
            OP_SUB:  r_val <= ram_rdata - top_q;
            OP_MUL:  r_val <= mul_lo;
            default: r_val <= ram_rdata;
          endcase
          state <= (op_q == OP_DIV) ? S_DIV : S_WB;
        end
        S_DIV: begin
          if (div_done) begin
            r_val <= div_quo;
            state <= S_WB;
          end
        end
        S_WB: begin
          top_q       <= r_val;
          sp          <= last_q ? '0 : sp_m1;
          pend_top    <= r_val;
          pend_status <= ST_OK;
          pend_depth  <= sp_m1;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.top_value   <= pend_top;
            res.status      <= pend_status;
            res.is_final    <= last_q;
            res.stack_depth <= pend_depth;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= PW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide wait");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && last_q) |=> sp == '0)
    else $error("stack not cleared after final token");

  a_wb_depth: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> sp >= PW'(2))
    else $error("operator write back with fewer than two entries");

endmodule
